[hw/rtl/per_session_window_rate_limiter_assert.svh]
// Assertion helpers for the rate limiter RTL.
// Each helper expects clk and rst_n in scope.
`ifndef PER_SESSION_WINDOW_RATE_LIMITER_ASSERT_SVH
`define PER_SESSION_WINDOW_RATE_LIMITER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define PSWRL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define PSWRL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define PSWRL_ASSERT_IMP(lbl, ante, cons, msg)
`define PSWRL_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

[hw/rtl/pswrl_pkg.sv]
package pswrl_pkg;

  // Stream payload widths (tdata byte padded)
  localparam int IN_TDATA_W  = 64;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 8;

  // Configuration port widths
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // capture accepted request
    logic age;    // evaluate window age
    logic cnt;    // update counters and table
    logic cmp;    // compare limits, load result
  } pswrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;  // result register can take a new value this cycle
  } pswrl_status_t;

endpackage

[hw/rtl/pswrl_ctrl.sv]
`include "per_session_window_rate_limiter_assert.svh"

module pswrl_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  pswrl_pkg::pswrl_status_t status,
  output pswrl_pkg::pswrl_cmd_t    cmd
);
  import pswrl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_AGE,
    S_CNT,
    S_CMP
  } state_t;

  state_t state_r;
  logic   accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  // Command decode
  always_comb begin
    cmd      = '0;
    cmd.load = accept;
    cmd.age  = (state_r == S_AGE);
    cmd.cnt  = (state_r == S_CNT);
    cmd.cmp  = (state_r == S_CMP) && status.out_free;
  end

  // Sequencer: read, age check, count, compare
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept) state_r <= S_RD;
        end
        S_RD:  state_r <= S_AGE;
        S_AGE: state_r <= S_CNT;
        S_CNT: state_r <= S_CMP;
        S_CMP: begin
          if (status.out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `PSWRL_ASSERT_NXT(a_accept_reads, accept, state_r == S_RD, "accept did not start a read")
  `PSWRL_ASSERT_NXT(a_cmp_stall, (state_r == S_CMP) && !status.out_free, state_r == S_CMP,
                    "left compare while result register full")
  `PSWRL_ASSERT_IMP(a_cmd_onehot, 1'b1, $onehot0({cmd.load, cmd.age, cmd.cnt, cmd.cmp}),
                    "overlapping datapath commands")

endmodule

[hw/rtl/pswrl_dp.sv]
`include "per_session_window_rate_limiter_assert.svh"

module pswrl_dp #(
  parameter int SESSIONS = 64
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [pswrl_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic [pswrl_pkg::IN_TUSER_W-1:0]      in_tuser,
  input  logic                                  cfg_we,
  input  logic [pswrl_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [pswrl_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [pswrl_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  pswrl_pkg::pswrl_cmd_t                 cmd,
  output pswrl_pkg::pswrl_status_t              status
);
  import pswrl_pkg::*;

  localparam int IDX_W = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_TICKS = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PACKETS  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_BYTES    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_INPUTS   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_CHUNKS   = 3'd4;

  // Packet class codes
  localparam logic [1:0] CLS_PLAYER_INPUT  = 2'd1;
  localparam logic [1:0] CLS_CHUNK_REQUEST = 2'd2;

  typedef struct packed {
    logic [31:0] wbegin;
    logic [15:0] pcnt;
    logic [31:0] bcnt;
    logic [15:0] icnt;
    logic [15:0] ccnt;
  } entry_t;

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    logic [15:0] r;
    r = (v == 16'hFFFF) ? v : v + 16'd1;
    return r;
  endfunction

  // Configuration registers
  logic [31:0] window_ticks_r;
  logic [15:0] max_packets_r;
  logic [31:0] max_bytes_r;
  logic [15:0] max_inputs_r;
  logic [15:0] max_chunks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_ticks_r <= 32'd1000000;
      max_packets_r  <= 16'd900;
      max_bytes_r    <= 32'd262144;
      max_inputs_r   <= 16'd360;
      max_chunks_r   <= 16'd120;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW_TICKS: window_ticks_r <= cfg_wdata;
        CFG_MAX_PACKETS:  max_packets_r  <= cfg_wdata[15:0];
        CFG_MAX_BYTES:    max_bytes_r    <= cfg_wdata;
        CFG_MAX_INPUTS:   max_inputs_r   <= cfg_wdata[15:0];
        CFG_MAX_CHUNKS:   max_chunks_r   <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Captured request
  logic        cmd_r;
  logic [5:0]  sess_r;
  logic [1:0]  cls_r;
  logic [19:0] bytes_r;
  logic [31:0] now_r;
  logic        known_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r   <= in_tuser[0];
      sess_r  <= in_tdata[5:0];
      cls_r   <= in_tdata[7:6];
      bytes_r <= in_tdata[27:8];
      now_r   <= in_tdata[59:28];
      known_r <= in_tdata[60];
    end
  end

  logic             in_range;
  logic             is_pkt;
  logic [IDX_W-1:0] idx;

  assign in_range = (32'(sess_r) < 32'(SESSIONS));
  assign is_pkt   = in_range && !cmd_r && known_r;
  assign idx      = IDX_W'(sess_r);

  // Window-started marks, cleared at reset and on session open
  logic [SESSIONS-1:0] started_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= '0;
    end else if (cmd.cnt && in_range) begin
      if (cmd_r) begin
        started_r[idx] <= 1'b0;
      end else if (known_r) begin
        started_r[idx] <= 1'b1;
      end
    end
  end

  // Session table memory
  entry_t mem [SESSIONS];
  entry_t rd_r;
  entry_t upd;

  always_ff @(posedge clk) begin
    rd_r <= mem[idx];
    if (cmd.cnt && is_pkt) begin
      mem[idx] <= upd;
    end
  end

  // Window age check
  logic        restart_r;
  logic [31:0] age;

  assign age = now_r - rd_r.wbegin;

  always_ff @(posedge clk) begin
    if (cmd.age) begin
      restart_r <= !started_r[idx] || (age >= window_ticks_r);
    end
  end

  // Counter update with saturation
  entry_t      base;
  logic [32:0] bsum;

  always_comb begin
    base = restart_r ? '0 : rd_r;
    bsum = {1'b0, base.bcnt} + {13'd0, bytes_r};
    upd        = base;
    upd.wbegin = restart_r ? now_r : rd_r.wbegin;
    upd.pcnt   = sat_inc16(base.pcnt);
    upd.bcnt   = bsum[32] ? 32'hFFFF_FFFF : bsum[31:0];
    if (cls_r == CLS_PLAYER_INPUT) upd.icnt = sat_inc16(base.icnt);
    if (cls_r == CLS_CHUNK_REQUEST) upd.ccnt = sat_inc16(base.ccnt);
  end

  logic [15:0] pcnt_r;
  logic [31:0] bcnt_r;
  logic [15:0] icnt_r;
  logic [15:0] ccnt_r;

  always_ff @(posedge clk) begin
    if (cmd.cnt) begin
      pcnt_r <= upd.pcnt;
      bcnt_r <= upd.bcnt;
      icnt_r <= upd.icnt;
      ccnt_r <= upd.ccnt;
    end
  end

  // Limit compare and result register
  logic exceed;
  logic out_valid_r;
  logic out_bit_r;

  assign exceed = is_pkt && ((pcnt_r > max_packets_r) || (bcnt_r > max_bytes_r) ||
                             (icnt_r > max_inputs_r) || (ccnt_r > max_chunks_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.cmp) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cmp) out_bit_r <= exceed;
  end

  assign out_tvalid      = out_valid_r;
  assign out_tdata       = {7'd0, out_bit_r};
  assign status.out_free = !out_valid_r || out_tready;

  `PSWRL_ASSERT_NXT(a_mark_set, cmd.cnt && is_pkt, started_r[idx],
                    "window mark not set after packet update")
  `PSWRL_ASSERT_IMP(a_result_src, $rose(out_tvalid), $past(cmd.cmp),
                    "result appeared without a compare step")

endmodule

[hw/rtl/per_session_window_rate_limiter.sv]
// Per-session fixed-window rate limiter.
// Input stream (in_*): one request per packet arrival or session open.
//   in_tuser[0] is the command (0 packet, 1 session opened); in_tdata
//   carries session, class, byte length, timestamp and a known flag.
// Result stream (out_*): exactly one result per request, out_tdata[0] is
//   the limit-exceeded flag (0 for opens, unknown or out-of-range sessions).
// Config port (cfg_*): write window length and the four limits while idle.
// Sequencing: a request passes through a registered table read, an age
//   compare, a counter update and a limit compare, each in its own
//   sequencer state on the single table port; the next request is
//   accepted only once the result is loaded.
// Reset (synchronous, rst_n low) clears all window marks and restores
//   register defaults; no clearing pass is needed.
// If the receiver holds out_tready low, the result waits in its register;
//   one more request is still accepted and processed up to the compare
//   step, where it waits until the register frees.
module per_session_window_rate_limiter #(
  parameter int SESSIONS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [5:0] session, [7:6] packet_class, [27:8] packet_bytes,
  // [59:28] now_ticks, [60] session_known, [63:61] zero
  input  logic [pswrl_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [0] cmd
  input  logic [pswrl_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [0] limit_exceeded, [7:1] zero
  output logic [pswrl_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                              cfg_we,
  input  logic [pswrl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pswrl_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import pswrl_pkg::*;

  pswrl_cmd_t    cmd;
  pswrl_status_t status;

  // Sequencer
  pswrl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // Session table, counters and limit compare
  pswrl_dp #(
    .SESSIONS (SESSIONS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .status     (status)
  );

endmodule
